[sv/h264_nal_fu_a_fragmenter_unit_assert.svh]
// assertion macros for the fu-a fragmenter
`ifndef H264_NAL_FU_A_FRAGMENTER_UNIT_ASSERT_SVH
`define H264_NAL_FU_A_FRAGMENTER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define H264FU_ASSERT_IMPL(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define H264FU_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

[sv/h264fu_pkg.sv]
// shared constants and types for the fu-a fragmenter
`timescale 1ns / 1ps
`default_nettype none

package h264fu_pkg;

   localparam int LEN_W      = 20;   // nal unit length width
   localparam int LIM_W      = 12;   // payload limit width
   localparam int BYTE_W     = 8;
   localparam int SLOT_CNT   = 3;    // most beats one input byte can cause
   localparam int CNT_W      = 2;

   localparam logic [LIM_W-1:0]  LIMIT_RESET = 12'd1400;
   localparam logic [BYTE_W-1:0] FU_A_TYPE   = 8'd28;
   localparam logic [BYTE_W-1:0] FU_S_BIT    = 8'h80;
   localparam logic [BYTE_W-1:0] FU_E_BIT    = 8'h40;
   localparam logic [BYTE_W-1:0] NRI_MASK    = 8'hE0;
   localparam logic [BYTE_W-1:0] TYPE_MASK   = 8'h1F;

   // one buffered result beat
   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              packet_end;
      logic              run_last;
   } slot_type;

endpackage

`default_nettype wire

[sv/h264_nal_fu_a_fragmenter_unit.sv]
// h.264 nal unit to fu-a payload fragmenter, top level
//
// usage
//  - req_* carries one nal unit byte per beat, header byte first, with the
//    unit length on every byte and req_nal_start on the header byte
//  - rsp_* carries payload beats: whole units up to the limit pass through,
//    longer ones come out as fu-a fragments, each opened by an fu indicator
//    and an fu header beat; rsp_packet_end marks the last beat of a packet,
//    rsp_run_last the last beat caused by one input byte
//  - csr_* writes the payload limit (reset 1400); write only while idle
// timing
//  - an accepted byte is held in the input register, then its beats load the
//    result buffer; the first beat is valid once the buffer has loaded
//  - one input byte per cycle in steady state while rsp_ready is high; when a
//    fragment opens, three beats load the buffer and the input stalls while
//    they drain (output port: one beat per cycle while rsp_ready is high)
//  - rsp_ready low holds the buffer; the input register still takes one
//    more byte before req_ready drops
// reset
//  - synchronous, clears all unit state and empties both buffers, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

`include "h264_nal_fu_a_fragmenter_unit_assert.svh"

module h264_nal_fu_a_fragmenter_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic [19:0] req_nal_size,
   input  wire logic        req_nal_start,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_packet_end,
   output logic             rsp_run_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [11:0] csr_max_payload_bytes
);

   localparam int LEN_W  = h264fu_pkg::LEN_W;
   localparam int LIM_W  = h264fu_pkg::LIM_W;
   localparam int BYTE_W = h264fu_pkg::BYTE_W;
   localparam int CNT_W  = h264fu_pkg::CNT_W;

   // config register
   logic [LIM_W-1:0] limit_ff;

   // input register
   logic              inp_valid_ff;
   logic [BYTE_W-1:0] inp_data_ff;
   logic [LEN_W-1:0]  inp_size_ff;
   logic              inp_start_ff;

   // unit state
   logic [BYTE_W-1:0] held_header_ff, held_header_in;
   logic [LEN_W-1:0]  bytes_seen_ff, bytes_seen_in;
   logic [LIM_W-1:0]  fill_ff, fill_in;
   logic              first_ff, first_in;
   logic              frag_ff, frag_in;
   logic [LEN_W-1:0]  unit_len_ff, unit_len_in;

   // result buffer, slot 0 drives the port
   h264fu_pkg::slot_type slot_ff [h264fu_pkg::SLOT_CNT];
   h264fu_pkg::slot_type slot_in [h264fu_pkg::SLOT_CNT];
   logic [CNT_W-1:0]     out_cnt_ff;
   logic [CNT_W-1:0]     new_cnt;

   logic load;
   logic take;

   // datapath temporaries
   logic [LIM_W-1:0]  lim;
   logic [LEN_W-1:0]  new_len;
   logic [LEN_W-1:0]  eff_len;
   logic [LIM_W-1:0]  eff_fill;
   logic              eff_first;
   logic              eff_frag;
   logic [BYTE_W-1:0] eff_hdr;
   logic              stray;
   logic [LEN_W-1:0]  idx;
   logic              unit_end;
   logic [LEN_W-1:0]  remaining;
   logic [BYTE_W-1:0] fu_ind;
   logic [BYTE_W-1:0] fu_hdr;
   logic              pend;
   logic [LIM_W:0]    fill_inc;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= h264fu_pkg::LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_max_payload_bytes;
      end
   end

   // buffer can load when empty or its last beat leaves now
   assign take = rsp_valid && rsp_ready;
   assign load = inp_valid_ff &&
                 ((out_cnt_ff == '0) || ((out_cnt_ff == CNT_W'(1)) && rsp_ready));
   assign req_ready = !inp_valid_ff || load;

   always_ff @(posedge clock) begin
      if (reset) begin
         inp_valid_ff <= 1'b0;
      end else if (req_ready) begin
         inp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         inp_data_ff  <= req_data_byte;
         inp_size_ff  <= req_nal_size;
         inp_start_ff <= req_nal_start;
      end
   end

   // unit processing for the byte in the input register
   always_comb begin
      lim     = (limit_ff == '0) ? LIM_W'(1) : limit_ff;
      new_len = (inp_size_ff == '0) ? LEN_W'(1) : inp_size_ff;

      // a start byte opens a fresh unit
      eff_len   = inp_start_ff ? new_len : unit_len_ff;
      idx       = inp_start_ff ? '0 : bytes_seen_ff;
      eff_fill  = inp_start_ff ? '0 : fill_ff;
      eff_first = inp_start_ff ? 1'b1 : first_ff;
      eff_frag  = inp_start_ff ? (new_len > LEN_W'(lim)) : frag_ff;
      eff_hdr   = inp_start_ff ? inp_data_ff : held_header_ff;

      // byte outside any open unit is dropped
      stray = !inp_start_ff && (bytes_seen_ff >= unit_len_ff);

      unit_end  = (idx + LEN_W'(1)) == eff_len;
      remaining = eff_len - idx;

      fu_ind = (eff_hdr & h264fu_pkg::NRI_MASK) | h264fu_pkg::FU_A_TYPE;
      fu_hdr = eff_hdr & h264fu_pkg::TYPE_MASK;
      if (eff_first) begin
         fu_hdr = fu_hdr | h264fu_pkg::FU_S_BIT;
      end
      if (remaining <= LEN_W'(lim)) begin
         fu_hdr = fu_hdr | h264fu_pkg::FU_E_BIT;
      end

      fill_inc = {1'b0, eff_fill} + (LIM_W+1)'(1);
      pend     = (fill_inc >= {1'b0, lim}) || unit_end;

      held_header_in = held_header_ff;
      bytes_seen_in  = bytes_seen_ff;
      fill_in        = fill_ff;
      first_in       = first_ff;
      frag_in        = frag_ff;
      unit_len_in    = unit_len_ff;
      new_cnt        = '0;
      for (int i = 0; i < h264fu_pkg::SLOT_CNT; i++) begin
         slot_in[i] = '{out_byte: inp_data_ff, packet_end: 1'b0, run_last: 1'b1};
      end

      if (!stray) begin
         held_header_in = eff_hdr;
         bytes_seen_in  = idx + LEN_W'(1);
         fill_in        = eff_fill;
         first_in       = eff_first;
         frag_in        = eff_frag;
         unit_len_in    = eff_len;
         if (!eff_frag) begin
            // unit fits: pass through
            slot_in[0] = '{out_byte: inp_data_ff, packet_end: unit_end, run_last: 1'b1};
            new_cnt    = CNT_W'(1);
         end else if (idx != '0) begin
            fill_in = pend ? '0 : fill_inc[LIM_W-1:0];
            if (eff_fill == '0) begin
               // fragment opens: indicator, fu header, then data
               first_in   = 1'b0;
               slot_in[0] = '{out_byte: fu_ind, packet_end: 1'b0, run_last: 1'b0};
               slot_in[1] = '{out_byte: fu_hdr, packet_end: 1'b0, run_last: 1'b0};
               slot_in[2] = '{out_byte: inp_data_ff, packet_end: pend, run_last: 1'b1};
               new_cnt    = CNT_W'(3);
            end else begin
               slot_in[0] = '{out_byte: inp_data_ff, packet_end: pend, run_last: 1'b1};
               new_cnt    = CNT_W'(1);
            end
         end
         // header byte of a fragmented unit is held, no beat
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_header_ff <= '0;
         bytes_seen_ff  <= '0;
         fill_ff        <= '0;
         first_ff       <= 1'b1;
         frag_ff        <= 1'b0;
         unit_len_ff    <= '0;
      end else if (load) begin
         held_header_ff <= held_header_in;
         bytes_seen_ff  <= bytes_seen_in;
         fill_ff        <= fill_in;
         first_ff       <= first_in;
         frag_ff        <= frag_in;
         unit_len_ff    <= unit_len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff <= '0;
      end else if (load) begin
         out_cnt_ff <= new_cnt;
      end else if (take) begin
         out_cnt_ff <= out_cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < h264fu_pkg::SLOT_CNT; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end else if (take) begin
         for (int i = 0; i < h264fu_pkg::SLOT_CNT - 1; i++) begin
            slot_ff[i] <= slot_ff[i+1];
         end
      end
   end

   assign rsp_valid      = (out_cnt_ff != '0);
   assign rsp_out_byte   = slot_ff[0].out_byte;
   assign rsp_packet_end = slot_ff[0].packet_end;
   assign rsp_run_last   = slot_ff[0].run_last;

   // checks
   `H264FU_ASSERT_IMPL(a_last_beat_run_last, clock, reset, out_cnt_ff == CNT_W'(1),
      slot_ff[0].run_last, "final buffered beat lacks run_last")
   `H264FU_ASSERT_IMPL(a_prefix_no_end, clock, reset, out_cnt_ff == CNT_W'(3),
      !slot_ff[0].packet_end && !slot_ff[1].packet_end, "fu prefix marked as packet end")
   `H264FU_ASSERT_IMPL(a_seen_in_range, clock, reset, 1'b1,
      bytes_seen_ff <= unit_len_ff, "byte count past unit length")
   `H264FU_ASSERT_NEXT(a_input_held, clock, reset, inp_valid_ff && !load,
      inp_valid_ff, "unprocessed input byte lost")

endmodule

`default_nettype wire

[test/tb_top.sv]
// self-checking testbench for the fu-a fragmenter: random and directed nal units
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned WATCHDOG_CYCLES = 400000;
   localparam int unsigned SETTLE_CYCLES   = 8;     // input register plus result buffer
   localparam int unsigned HOLD_AT_BYTE    = 380;   // accepted bytes before the long stall
   localparam int unsigned HOLD_CYCLES     = 300;

   // one input byte as queued for the driver
   typedef struct {
      logic [7:0]  data;
      logic [19:0] size;
      logic        start;
      bit          drain_first;   // sender waits for every payload beat first
   } nal_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = '0;
   logic [19:0] req_nal_size = '0;
   logic        req_nal_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_packet_end;
   logic        rsp_run_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [11:0] csr_max_payload_bytes = '0;

   h264_nal_fu_a_fragmenter_unit i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_data_byte         (req_data_byte),
      .req_nal_size          (req_nal_size),
      .req_nal_start         (req_nal_start),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_out_byte          (rsp_out_byte),
      .rsp_packet_end        (rsp_packet_end),
      .rsp_run_last          (rsp_run_last),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_max_payload_bytes (csr_max_payload_bytes)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // stimulus and expectation stores
   nal_byte_type          pending_bytes[$];
   h264fu_pkg::slot_type  expected_beats[$];

   // bookkeeping, all but n_fail updated with nonblocking writes so every process
   // sees the values from before the edge
   int unsigned n_acc  = 0;   // input bytes accepted
   int unsigned n_pred = 0;   // payload beats predicted
   int unsigned n_seen = 0;   // payload beats checked
   int unsigned n_fail = 0;
   int unsigned cycle_cnt = 0;

   // --------------------------------------------------------------------
   // packetizer shadow: limit register and per-unit state
   // --------------------------------------------------------------------
   logic [11:0] payload_limit = h264fu_pkg::LIMIT_RESET;
   logic [7:0]  held_hdr      = '0;
   logic [19:0] seen_cnt      = '0;
   logic [11:0] frag_fill     = '0;
   logic        s_pending     = 1'b1;
   logic        fragmenting   = 1'b0;
   logic [19:0] unit_len      = '0;

   function automatic void queue_beat(input logic [7:0] b, input logic pe, input logic rl);
      expected_beats.push_back({b, pe, rl});
   endfunction

   // advance the shadow by one accepted byte, queue its payload beats and
   // return how many there are
   function automatic int unsigned packetize_byte(input logic [7:0] data,
                                                  input logic [19:0] size,
                                                  input logic start);
      int unsigned lim;
      int unsigned idx;
      int unsigned remaining;
      int unsigned made;
      logic        unit_end;
      logic        pend;
      logic [7:0]  fu_hdr;
      // a zero limit behaves as a limit of one
      lim  = (payload_limit == 0) ? 1 : 32'(payload_limit);
      made = 0;
      if (start) begin
         // zero length counts as a one-byte unit; a start mid-unit drops the old one
         unit_len    = (size == 0) ? 20'd1 : size;
         seen_cnt    = '0;
         frag_fill   = '0;
         s_pending   = 1'b1;
         fragmenting = (unit_len > lim);
         held_hdr    = data;
      end else if (seen_cnt >= unit_len) begin
         // stray byte outside any unit
         return 0;
      end
      idx      = 32'(seen_cnt);
      seen_cnt = 20'(idx + 1);
      unit_end = ((idx + 1) == unit_len);
      if (!fragmenting) begin
         queue_beat(data, unit_end, 1'b1);
         return 1;
      end
      // header of a fragmented unit is only held
      if (idx == 0)
         return 0;
      if (frag_fill == 0) begin
         // new fragment: indicator and fu header; e bit uses the limit in force now
         remaining = unit_len - idx;
         fu_hdr = held_hdr & h264fu_pkg::TYPE_MASK;
         if (s_pending)
            fu_hdr = fu_hdr | h264fu_pkg::FU_S_BIT;
         if (remaining <= lim)
            fu_hdr = fu_hdr | h264fu_pkg::FU_E_BIT;
         s_pending = 1'b0;
         queue_beat((held_hdr & h264fu_pkg::NRI_MASK) | h264fu_pkg::FU_A_TYPE, 1'b0, 1'b0);
         queue_beat(fu_hdr, 1'b0, 1'b0);
         made = 2;
      end
      pend = ((frag_fill + 1) >= lim) || unit_end;
      queue_beat(data, pend, 1'b1);
      frag_fill = pend ? 12'd0 : frag_fill + 12'd1;
      return made + 1;
   endfunction

   // --------------------------------------------------------------------
   // idling: sender 28 / receiver 70, then swapped, then none
   // --------------------------------------------------------------------
   int unsigned send_gap_pct;
   int unsigned recv_gap_pct;
   assign send_gap_pct = (n_acc < 170) ? 28 : (n_acc < 340) ? 70 : 0;
   assign recv_gap_pct = (n_acc < 170) ? 70 : (n_acc < 340) ? 28 : 0;

   // --------------------------------------------------------------------
   // driver: presents queued bytes, predicts each one at its accepting edge
   // --------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      bit           offer;
      nal_byte_type nxt;
      int unsigned  made;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         made = 0;
         if (req_valid && req_ready) begin
            made = packetize_byte(req_data_byte, req_nal_size, req_nal_start);
            n_acc <= n_acc + 1;
         end
         n_pred <= n_pred + made;
         // the channel is free for a new beat when nothing is offered or it was just taken
         if (!req_valid || req_ready) begin
            offer = (pending_bytes.size() != 0) && ($urandom_range(0, 99) >= send_gap_pct);
            // pause point: hold the next byte until the output has fully drained
            if (offer && pending_bytes[0].drain_first && (n_pred + made) != n_seen)
               offer = 1'b0;
            if (offer) begin
               nxt = pending_bytes.pop_front();
               req_valid     <= 1'b1;
               req_data_byte <= nxt.data;
               req_nal_size  <= nxt.size;
               req_nal_start <= nxt.start;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------------
   // receiver: random ready, plus one long hold-off once traffic is steady
   // --------------------------------------------------------------------
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && n_acc >= HOLD_AT_BYTE) begin
         // the block fills up and must push back on req_ready
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
   end

   // --------------------------------------------------------------------
   // monitor: each payload beat against the oldest expectation
   // --------------------------------------------------------------------
   always @(posedge clock) begin : check_rsp
      h264fu_pkg::slot_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (n_seen == n_pred) begin
            if (n_fail < 10)
               $display("payload beat %02h end %b last %b with nothing expected",
                        rsp_out_byte, rsp_packet_end, rsp_run_last);
            n_fail++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_out_byte !== want.out_byte || rsp_packet_end !== want.packet_end ||
                rsp_run_last !== want.run_last) begin
               if (n_fail < 10)
                  $display("beat %0d: expected byte %02h end %b last %b, got %02h %b %b",
                           n_seen, want.out_byte, want.packet_end, want.run_last,
                           rsp_out_byte, rsp_packet_end, rsp_run_last);
               n_fail++;
            end
            n_seen <= n_seen + 1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == WATCHDOG_CYCLES) begin
         $display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt, n_pred - n_seen);
         $display("== FAIL ==");
         $finish;
      end
   end

   // --------------------------------------------------------------------
   // stimulus helpers
   // --------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] data, input logic [19:0] size,
                            input logic start, input bit drain_first);
      nal_byte_type b;
      b.data = data;
      b.size = size;
      b.start = start;
      b.drain_first = drain_first;
      pending_bytes.push_back(b);
   endtask

   // first cut bytes of a unit of len bytes; cut < len leaves it for an early restart
   task automatic push_unit(input int unsigned len, input int unsigned cut, input bit drain_first);
      logic [19:0] sz;
      for (int unsigned i = 0; i < cut; i++) begin
         if (i == 0)
            sz = (len == 1 && $urandom_range(0, 1) == 1) ? 20'd0 : len[19:0];
         else
            // size only matters on the header byte, so scramble it elsewhere
            sz = ($urandom_range(0, 3) == 0) ? 20'($urandom_range(0, 20'hFFFFF)) : len[19:0];
         push_byte(8'($urandom_range(0, 255)), sz, i == 0, drain_first && i == 0);
      end
   endtask

   function automatic int unsigned pick_length(input int unsigned lim);
      case ($urandom_range(0, 5))
         0:       return $urandom_range(1, (lim < 40) ? lim : 40);
         1:       return (lim <= 100) ? lim : $urandom_range(1, 40);          // exactly the limit
         2:       return (lim <= 100) ? lim + 1 : $urandom_range(1, 40);      // one fragment
         3:       return (lim <= 40) ? $urandom_range(2, 3) * lim + 1 : $urandom_range(1, 40);
         default: return $urandom_range(1, (lim * 3 + 2 < 100) ? lim * 3 + 2 : 100);
      endcase
   endfunction

   // mostly whole units with random content; some strays and abandoned units
   task automatic random_phase(input int unsigned limit, input int unsigned n_bytes);
      int unsigned lim;
      int unsigned made;
      int unsigned units;
      int unsigned len;
      int unsigned cut;
      int unsigned r;
      lim = (limit == 0) ? 1 : limit;
      made = 0;
      units = 0;
      while (made < n_bytes) begin
         r = $urandom_range(0, 99);
         if (r < 8) begin
            push_byte(8'($urandom_range(0, 255)), 20'($urandom_range(0, 20'hFFFFF)),
                      1'b0, 1'b0);
         end else begin
            len = pick_length(lim);
            cut = len;
            if (r < 18 && len > 1)
               cut = $urandom_range(1, len - 1);
            push_unit(len, cut, (units % 12) == 1);
            made += cut;
            units++;
         end
      end
   endtask

   // wait until the driver is empty and every predicted beat has been checked
   task automatic wait_idle;
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || n_pred != n_seen);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [11:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_max_payload_bytes <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      payload_limit = value;
      @(negedge clock);
   endtask

   // --------------------------------------------------------------------
   // test sequence
   // --------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset limit: strays, zero length, pass-through, abandoned fragmented unit
      push_byte(8'hA5, 20'hFFFFF, 1'b0, 1'b0);     // stray before any unit
      push_byte(8'hFF, 20'h00000, 1'b1, 1'b0);     // zero length unit
      push_byte(8'h00, 20'd3, 1'b1, 1'b0);
      push_byte(8'hFF, 20'd3, 1'b0, 1'b0);
      push_byte(8'h80, 20'd3, 1'b0, 1'b0);
      push_byte(8'h5A, 20'h00000, 1'b0, 1'b0);     // stray after a finished unit
      push_byte(8'h7C, 20'hFFFFF, 1'b1, 1'b0);     // huge unit, fragmented
      push_byte(8'h12, 20'hFFFFF, 1'b0, 1'b0);
      push_byte(8'h34, 20'h55555, 1'b0, 1'b0);
      push_byte(8'h41, 20'd2, 1'b1, 1'b0);         // early restart
      push_byte(8'h01, 20'hAAAAA, 1'b0, 1'b0);
      wait_idle();

      // zero limit acts as one: single fragment with s and e, then a short unit
      write_limit(12'd0);
      push_byte(8'hE5, 20'd2, 1'b1, 1'b0);
      push_byte(8'h33, 20'd2, 1'b0, 1'b0);
      push_byte(8'h9F, 20'd1, 1'b1, 1'b0);
      // limit raised in the middle of a fragmented unit
      push_byte(8'h65, 20'd6, 1'b1, 1'b0);
      push_byte(8'hC3, 20'd6, 1'b0, 1'b0);
      push_byte(8'h3C, 20'd6, 1'b0, 1'b0);
      wait_idle();
      write_limit(12'd16);
      push_byte(8'h11, 20'd6, 1'b0, 1'b0);
      push_byte(8'h22, 20'd6, 1'b0, 1'b0);
      push_byte(8'hFF, 20'd6, 1'b0, 1'b0);
      wait_idle();

      // random traffic at the smallest limit
      random_phase(16, 120);
      wait_idle();

      // largest limit: an abandoned huge unit, then mostly pass-through
      write_limit(12'd4095);
      push_unit($urandom_range(4096, 20'hFFFFF), 12, 1'b0);
      random_phase(4095, 40);
      wait_idle();

      write_limit(12'($urandom_range(17, 48)));
      random_phase(32'(payload_limit), 130);
      wait_idle();

      write_limit(12'($urandom_range(16, 24)));
      random_phase(32'(payload_limit), 90);
      wait_idle();

      // anything still expected was never delivered
      n_fail += expected_beats.size();
      $display("fragmenter run: %0d input bytes, %0d payload beats checked", n_acc, n_seen);
      $display("limits zero, 16, 4095 and random; strays, restarts, mid-unit limit change");
      if (n_fail == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d failures", n_fail);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
